// ----- rtl/lpmr_pkg.sv -----
// Shared types, codes and constants for the length-prefixed message ring.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package lpmr_pkg;

    // Default sizing, handed to the top-level parameters.
    localparam int RING_DEPTH_DEF  = 1024;
    localparam int MAX_MESSAGE_DEF = 64;

    // Each message starts with a 4-byte little-endian length header.
    localparam int HEADER_BYTES = 4;

    // Smallest ring size that the size register can select.
    localparam int MIN_RING = 8;

    // Widest ring address that the memory request can carry.
    localparam int MEM_ADDR_MAX_W = 16;

    // Configuration port.
    localparam int          PADDR_W         = 2;
    localparam int          PDATA_W         = 32;
    localparam int          RING_SIZE_W     = 11;
    localparam logic [PADDR_W-1:0] ADDR_RING_SIZE = 2'd0;
    localparam logic [RING_SIZE_W-1:0] RING_SIZE_RESET = 11'd1024;

    // Actions carried by an input beat.
    localparam logic [2:0] ACT_SEND_BEGIN = 3'd0;
    localparam logic [2:0] ACT_SEND_BYTE  = 3'd1;
    localparam logic [2:0] ACT_RECEIVE    = 3'd2;
    localparam logic [2:0] ACT_FLUSH      = 3'd3;
    localparam logic [2:0] ACT_STATUS     = 3'd4;

    // Status codes carried by an output beat.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_SPACE = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_BAD_LEN  = 3'd3;
    localparam logic [2:0] ST_CORRUPT  = 3'd4;
    localparam logic [2:0] ST_SEQ_ERR  = 3'd5;

    // Input beat.
    typedef struct packed {
        logic [2:0] action;
        logic [7:0] length;
        logic [7:0] in_byte;
    } t_in_beat;

    // Output beat.
    typedef struct packed {
        logic [2:0] status;
        logic [7:0] out_byte;
        logic       last;
        logic [6:0] count;
        logic [9:0] used_bytes;
        logic [9:0] free_bytes;
        logic [9:0] peak_bytes;
        logic [6:0] next_length;
        logic       is_empty;
        logic       is_full;
    } t_out_beat;

    // One access to the ring memory; reads and writes never share a cycle.
    typedef struct packed {
        logic                      we;
        logic                      re;
        logic [MEM_ADDR_MAX_W-1:0] addr;
        logic [7:0]                wdata;
    } t_mem_req;

    // Size register contents and its write strobe.
    typedef struct packed {
        logic                   wr;
        logic [RING_SIZE_W-1:0] ring_size;
    } t_cfg;

endpackage

`default_nettype wire

// ----- rtl/lpmr_mem.sv -----
// Byte ring storage: one write or one read per cycle, read data registered.
// Depends on lpmr_pkg for the access request type.
`timescale 1ns / 1ps
`default_nettype none

module lpmr_mem #(
    parameter int RING_DEPTH = lpmr_pkg::RING_DEPTH_DEF
) (
    input  wire logic                i_clk,
    input  wire lpmr_pkg::t_mem_req  i_req,
    output logic [7:0]               o_rdata
);

    localparam int AW = $clog2(RING_DEPTH);

    logic [7:0] r_mem [RING_DEPTH];
    logic [7:0] r_rdata;

    // Single-port array with a registered read.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr[AW-1:0]] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.addr[AW-1:0]];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/lpmr_apb.sv -----
// Configuration register file: the ring size register behind an APB-style port.
// Depends on lpmr_pkg for the address map and the register strobe type.
`timescale 1ns / 1ps
`default_nettype none

module lpmr_apb (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [lpmr_pkg::PADDR_W-1:0]         paddr,
    input  wire logic [lpmr_pkg::PDATA_W-1:0]         pwdata,
    output logic      [lpmr_pkg::PDATA_W-1:0]         prdata,
    output logic                                      pready,
    output lpmr_pkg::t_cfg                            o_cfg
);

    logic [lpmr_pkg::RING_SIZE_W-1:0] r_ring_size;
    logic                             w_wr;

    // A write lands in the access phase of the transfer.
    assign w_wr = psel && penable && pwrite && (paddr == lpmr_pkg::ADDR_RING_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_size <= lpmr_pkg::RING_SIZE_RESET;
        end else if (w_wr) begin
            r_ring_size <= pwdata[lpmr_pkg::RING_SIZE_W-1:0];
        end
    end

    // Read back; unmapped addresses read as zero.
    always_comb begin
        if (paddr == lpmr_pkg::ADDR_RING_SIZE) begin
            prdata = lpmr_pkg::PDATA_W'(r_ring_size);
        end else begin
            prdata = '0;
        end
    end

    assign pready        = 1'b1;
    assign o_cfg.wr        = w_wr;
    assign o_cfg.ring_size = r_ring_size;

endmodule

`default_nettype wire

// ----- rtl/lpmr_ctrl.sv -----
// Sequencer of the message ring: pointers, counts, open-send tracking and the
// output register. Depends on lpmr_pkg; drives the lpmr_mem access port.
`timescale 1ns / 1ps
`default_nettype none

module lpmr_ctrl #(
    parameter int RING_DEPTH  = lpmr_pkg::RING_DEPTH_DEF,
    parameter int MAX_MESSAGE = lpmr_pkg::MAX_MESSAGE_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire lpmr_pkg::t_cfg       i_cfg,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire lpmr_pkg::t_in_beat   i_in_beat,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output lpmr_pkg::t_out_beat       o_out_beat,
    output lpmr_pkg::t_mem_req        o_mem_req,
    input  wire logic [7:0]           i_mem_rdata
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int EW = AW + 1;
    localparam int SW = AW + 8;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_HDR   = 3'd2;
    localparam logic [2:0] S_RHDR  = 3'd3;
    localparam logic [2:0] S_RHDR2 = 3'd4;
    localparam logic [2:0] S_RREAD = 3'd5;
    localparam logic [2:0] S_RDATA = 3'd6;
    localparam logic [2:0] S_EMIT  = 3'd7;

    // Control state.
    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [AW-1:0] r_used, n_used;
    logic [AW-1:0] r_peak, n_peak;
    logic          r_open, n_open;
    logic [6:0]    r_rem, n_rem;
    logic [AW-1:0] r_pend_ptr, n_pend_ptr;
    logic [6:0]    r_pend_total, n_pend_total;
    logic          r_out_valid, n_out_valid;

    // Payload and working registers.
    lpmr_pkg::t_in_beat  r_cmd, n_cmd;
    lpmr_pkg::t_out_beat r_out, n_out;
    logic [7:0]          r_head, n_head;
    logic [1:0]          r_hcnt, n_hcnt;
    logic [AW-1:0]       r_hptr, n_hptr;
    logic [AW-1:0]       r_rx_ptr, n_rx_ptr;
    logic [6:0]          r_rx_n, n_rx_n;
    logic [6:0]          r_rx_i, n_rx_i;
    logic [2:0]          r_res_status, n_res_status;
    logic [6:0]          r_res_count, n_res_count;

    // Derived values.
    logic [EW-1:0] w_eff;
    logic [AW-1:0] w_cap;
    logic [AW-1:0] w_free;
    logic          w_out_free;
    logic [6:0]    w_next_len;
    logic [31:0]   w_used32;
    logic [31:0]   w_free32;
    logic [31:0]   w_peak32;
    logic [AW-1:0] w_new_pend;
    logic [6:0]    w_new_rem;
    logic [AW-1:0] w_new_used;
    logic [6:0]    w_rx_count;
    logic          w_rx_last;
    lpmr_pkg::t_mem_req w_mem;

    // Advance a ring pointer; the step is always below the ring size.
    function automatic logic [AW-1:0] f_adv(input logic [AW-1:0] p, input logic [7:0] n,
                                            input logic [EW-1:0] eff);
        logic [SW-1:0] sum;
        sum = SW'(p) + SW'(n);
        if (sum >= SW'(eff)) begin
            sum = sum - SW'(eff);
        end
        return sum[AW-1:0];
    endfunction

    // Effective ring size: the register clamped to the supported range.
    always_comb begin
        if (i_cfg.ring_size < lpmr_pkg::RING_SIZE_W'(lpmr_pkg::MIN_RING)) begin
            w_eff = EW'(lpmr_pkg::MIN_RING);
        end else if (32'(i_cfg.ring_size) > 32'(RING_DEPTH)) begin
            w_eff = EW'(RING_DEPTH);
        end else begin
            w_eff = EW'(i_cfg.ring_size);
        end
    end

    assign w_cap  = AW'(w_eff - EW'(1));
    assign w_free = (r_used >= w_cap) ? '0 : (w_cap - r_used);

    // Length of the oldest committed message, cached from its header.
    always_comb begin
        if (SW'(r_used) >= SW'(lpmr_pkg::HEADER_BYTES) && 32'(r_head) <= 32'(MAX_MESSAGE)) begin
            w_next_len = r_head[6:0];
        end else begin
            w_next_len = '0;
        end
    end

    assign w_used32   = 32'(r_used);
    assign w_free32   = 32'(w_free);
    assign w_peak32   = 32'(r_peak);
    assign w_out_free = !r_out_valid || i_out_ready;

    // Send byte arithmetic.
    assign w_new_pend = f_adv(r_pend_ptr, 8'd1, w_eff);
    assign w_new_rem  = (r_rem != 7'd0) ? (r_rem - 7'd1) : 7'd0;
    assign w_new_used = AW'(SW'(r_used) + SW'(lpmr_pkg::HEADER_BYTES) + SW'(r_pend_total));

    // Receive byte bookkeeping.
    assign w_rx_count = r_rx_i + 7'd1;
    assign w_rx_last  = (w_rx_count == r_rx_n);

    // Next-state logic of the sequencer.
    always_comb begin
        n_state      = r_state;
        n_wr_ptr     = r_wr_ptr;
        n_rd_ptr     = r_rd_ptr;
        n_used       = r_used;
        n_peak       = r_peak;
        n_open       = r_open;
        n_rem        = r_rem;
        n_pend_ptr   = r_pend_ptr;
        n_pend_total = r_pend_total;
        n_out_valid  = r_out_valid;
        n_cmd        = r_cmd;
        n_out        = r_out;
        n_head       = r_head;
        n_hcnt       = r_hcnt;
        n_hptr       = r_hptr;
        n_rx_ptr     = r_rx_ptr;
        n_rx_n       = r_rx_n;
        n_rx_i       = r_rx_i;
        n_res_status = r_res_status;
        n_res_count  = r_res_count;
        w_mem        = '0;

        // The output register empties when its beat is taken.
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = i_in_beat;
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                n_res_status = lpmr_pkg::ST_OK;
                n_res_count  = '0;
                n_state      = S_EMIT;
                case (r_cmd.action)
                    lpmr_pkg::ACT_SEND_BEGIN: begin
                        if (r_open) begin
                            n_res_status = lpmr_pkg::ST_SEQ_ERR;
                        end else if (r_cmd.length == 8'd0 ||
                                     32'(r_cmd.length) > 32'(MAX_MESSAGE)) begin
                            n_res_status = lpmr_pkg::ST_BAD_LEN;
                        end else if (SW'(w_free) <
                                     SW'(lpmr_pkg::HEADER_BYTES) + SW'(r_cmd.length)) begin
                            n_res_status = lpmr_pkg::ST_NO_SPACE;
                        end else begin
                            n_hptr  = r_wr_ptr;
                            n_hcnt  = '0;
                            n_state = S_HDR;
                        end
                    end

                    lpmr_pkg::ACT_SEND_BYTE: begin
                        if (!r_open) begin
                            n_res_status = lpmr_pkg::ST_SEQ_ERR;
                        end else begin
                            w_mem.we    = 1'b1;
                            w_mem.addr  = lpmr_pkg::MEM_ADDR_MAX_W'(r_pend_ptr);
                            w_mem.wdata = r_cmd.in_byte;
                            n_pend_ptr  = w_new_pend;
                            n_rem       = w_new_rem;
                            n_res_count = r_pend_total - w_new_rem;
                            // Commit the message with its last data byte.
                            if (w_new_rem == 7'd0) begin
                                n_wr_ptr = w_new_pend;
                                n_used   = w_new_used;
                                n_open   = 1'b0;
                                if (w_new_used > r_peak) begin
                                    n_peak = w_new_used;
                                end
                                if (r_used == '0) begin
                                    n_head = {1'b0, r_pend_total};
                                end
                            end
                        end
                    end

                    lpmr_pkg::ACT_RECEIVE: begin
                        if (r_cmd.length == 8'd0) begin
                            n_res_status = lpmr_pkg::ST_BAD_LEN;
                        end else if (SW'(r_used) < SW'(lpmr_pkg::HEADER_BYTES)) begin
                            n_res_status = lpmr_pkg::ST_EMPTY;
                        end else if (32'(r_head) > 32'(MAX_MESSAGE) ||
                                     SW'(r_used) < SW'(lpmr_pkg::HEADER_BYTES) + SW'(r_head)) begin
                            n_res_status = lpmr_pkg::ST_CORRUPT;
                            n_wr_ptr     = '0;
                            n_rd_ptr     = '0;
                            n_used       = '0;
                            n_open       = 1'b0;
                            n_rem        = '0;
                            n_pend_ptr   = '0;
                            n_pend_total = '0;
                        end else begin
                            // Consume the whole message now, stream its bytes next.
                            n_rx_n   = (r_head < r_cmd.length) ? r_head[6:0] : r_cmd.length[6:0];
                            n_rx_i   = '0;
                            n_rx_ptr = f_adv(r_rd_ptr, 8'(lpmr_pkg::HEADER_BYTES), w_eff);
                            n_rd_ptr = f_adv(r_rd_ptr,
                                             8'(lpmr_pkg::HEADER_BYTES) + r_head, w_eff);
                            n_used   = AW'(SW'(r_used) - SW'(lpmr_pkg::HEADER_BYTES)
                                           - SW'(r_head));
                            n_state  = S_RHDR;
                        end
                    end

                    lpmr_pkg::ACT_FLUSH: begin
                        n_wr_ptr     = '0;
                        n_rd_ptr     = '0;
                        n_used       = '0;
                        n_open       = 1'b0;
                        n_rem        = '0;
                        n_pend_ptr   = '0;
                        n_pend_total = '0;
                    end

                    lpmr_pkg::ACT_STATUS: begin
                        n_res_status = lpmr_pkg::ST_OK;
                    end

                    default: begin
                        n_res_status = lpmr_pkg::ST_SEQ_ERR;
                    end
                endcase
            end

            // Write the length header, low byte first, one byte a cycle.
            S_HDR: begin
                w_mem.we    = 1'b1;
                w_mem.addr  = lpmr_pkg::MEM_ADDR_MAX_W'(r_hptr);
                w_mem.wdata = (r_hcnt == 2'd0) ? r_cmd.length : 8'd0;
                n_hptr      = f_adv(r_hptr, 8'd1, w_eff);
                n_hcnt      = r_hcnt + 2'd1;
                if (r_hcnt == 2'(lpmr_pkg::HEADER_BYTES - 1)) begin
                    n_pend_ptr   = f_adv(r_hptr, 8'd1, w_eff);
                    n_pend_total = r_cmd.length[6:0];
                    n_rem        = r_cmd.length[6:0];
                    n_open       = 1'b1;
                    n_res_status = lpmr_pkg::ST_OK;
                    n_res_count  = '0;
                    n_state      = S_EMIT;
                end
            end

            // Fetch the low header byte of the new oldest message.
            S_RHDR: begin
                w_mem.re   = 1'b1;
                w_mem.addr = lpmr_pkg::MEM_ADDR_MAX_W'(r_rd_ptr);
                n_state    = S_RHDR2;
            end

            S_RHDR2: begin
                n_head = i_mem_rdata;
                if (r_rx_n == 7'd0) begin
                    n_res_status = lpmr_pkg::ST_OK;
                    n_res_count  = '0;
                    n_state      = S_EMIT;
                end else begin
                    n_state = S_RREAD;
                end
            end

            S_RREAD: begin
                w_mem.re   = 1'b1;
                w_mem.addr = lpmr_pkg::MEM_ADDR_MAX_W'(r_rx_ptr);
                n_rx_ptr   = f_adv(r_rx_ptr, 8'd1, w_eff);
                n_state    = S_RDATA;
            end

            // Hand one received byte to the output register.
            S_RDATA: begin
                if (w_out_free) begin
                    n_out.status      = lpmr_pkg::ST_OK;
                    n_out.out_byte    = i_mem_rdata;
                    n_out.last        = w_rx_last;
                    n_out.count       = w_rx_count;
                    n_out.used_bytes  = w_used32[9:0];
                    n_out.free_bytes  = w_free32[9:0];
                    n_out.peak_bytes  = w_peak32[9:0];
                    n_out.next_length = w_next_len;
                    n_out.is_empty    = (r_used == '0);
                    n_out.is_full     = (SW'(w_free) < SW'(lpmr_pkg::HEADER_BYTES + 1));
                    n_out_valid       = 1'b1;
                    n_rx_i            = w_rx_count;
                    n_state           = w_rx_last ? S_IDLE : S_RREAD;
                end
            end

            // Single-beat result, shown with the state after the item.
            S_EMIT: begin
                if (w_out_free) begin
                    n_out.status      = r_res_status;
                    n_out.out_byte    = 8'd0;
                    n_out.last        = 1'b1;
                    n_out.count       = r_res_count;
                    n_out.used_bytes  = w_used32[9:0];
                    n_out.free_bytes  = w_free32[9:0];
                    n_out.peak_bytes  = w_peak32[9:0];
                    n_out.next_length = w_next_len;
                    n_out.is_empty    = (r_used == '0);
                    n_out.is_full     = (SW'(w_free) < SW'(lpmr_pkg::HEADER_BYTES + 1));
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A size write empties the ring and drops an open send; peak stays.
        if (i_cfg.wr) begin
            n_wr_ptr     = '0;
            n_rd_ptr     = '0;
            n_used       = '0;
            n_open       = 1'b0;
            n_rem        = '0;
            n_pend_ptr   = '0;
            n_pend_total = '0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_used       <= '0;
            r_peak       <= '0;
            r_open       <= 1'b0;
            r_rem        <= '0;
            r_pend_ptr   <= '0;
            r_pend_total <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_wr_ptr     <= n_wr_ptr;
            r_rd_ptr     <= n_rd_ptr;
            r_used       <= n_used;
            r_peak       <= n_peak;
            r_open       <= n_open;
            r_rem        <= n_rem;
            r_pend_ptr   <= n_pend_ptr;
            r_pend_total <= n_pend_total;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload and working registers.
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_out        <= n_out;
        r_head       <= n_head;
        r_hcnt       <= n_hcnt;
        r_hptr       <= n_hptr;
        r_rx_ptr     <= n_rx_ptr;
        r_rx_n       <= n_rx_n;
        r_rx_i       <= n_rx_i;
        r_res_status <= n_res_status;
        r_res_count  <= n_res_count;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;
    assign o_mem_req   = w_mem;

endmodule

`default_nettype wire

// ----- rtl/length_prefixed_message_ring.sv -----
// Top level of the length-prefixed message ring: ring memory, sequencer and
// size register. Depends on lpmr_pkg, lpmr_mem, lpmr_ctrl and lpmr_apb.
//
//   Channel   Direction  Handshake                Payload
//   in        input      i_in_valid / o_in_ready  i_in_beat  (t_in_beat)
//   out       output     o_out_valid / i_out_ready o_out_beat (t_out_beat)
//   config    input      psel, penable, pready    paddr, pwdata, prdata
//
// Status query, flush, send byte and refused items pass through the execute and
// emit states before the next accept; an accepted send begin also writes the 4
// header bytes through the single memory port one per cycle. A receive fetches
// the next header; each delivered byte is one memory read and one output load.
// Reset is synchronous and active low; the ring contents are not cleared.
// A stalled output holds its beat; the next item is taken while it waits.
`timescale 1ns / 1ps
`default_nettype none

module length_prefixed_message_ring #(
    parameter int RING_DEPTH  = lpmr_pkg::RING_DEPTH_DEF,
    parameter int MAX_MESSAGE = lpmr_pkg::MAX_MESSAGE_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire lpmr_pkg::t_in_beat            i_in_beat,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output lpmr_pkg::t_out_beat                o_out_beat,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lpmr_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [lpmr_pkg::PDATA_W-1:0]  pwdata,
    output logic      [lpmr_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready
);

    lpmr_pkg::t_cfg     w_cfg;
    lpmr_pkg::t_mem_req w_mem_req;
    logic [7:0]         w_mem_rdata;

    // Size register.
    lpmr_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Sequencer.
    lpmr_ctrl #(
        .RING_DEPTH  (RING_DEPTH),
        .MAX_MESSAGE (MAX_MESSAGE)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat),
        .o_mem_req   (w_mem_req),
        .i_mem_rdata (w_mem_rdata)
    );

    // Ring storage.
    lpmr_mem #(
        .RING_DEPTH (RING_DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_req   (w_mem_req),
        .o_rdata (w_mem_rdata)
    );

endmodule

`default_nettype wire

// ----- rtl/lpmr_checker.sv -----
// Port-level checks for the message ring, bound to the top level.
// Depends on lpmr_pkg for the beat type and the status codes.
`timescale 1ns / 1ps
`default_nettype none

module lpmr_checker (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_in_valid,
    input wire logic                 o_in_ready,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_ready,
    input wire lpmr_pkg::t_out_beat  o_out_beat
);

    // A stalled output beat stays and holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_beat))
        else $error("output beat changed while stalled");

    // Items are handled one at a time: ready drops after every accept.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second item accepted while one is in work");

    // A refused item yields a single beat with no data.
    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.status != lpmr_pkg::ST_OK |->
            o_out_beat.last && o_out_beat.out_byte == 8'd0 && o_out_beat.count == 7'd0)
        else $error("error beat carries data or is not last");

    // No new item is taken while a receive still has bytes to deliver.
    a_rx_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_beat.last |-> !o_in_ready)
        else $error("input ready in the middle of a receive");

endmodule

bind length_prefixed_message_ring lpmr_checker u_lpmr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_beat  (o_out_beat)
);

`default_nettype wire

// ----- dv/length_prefixed_message_ring_checker.sv -----
// Checker for the length-prefixed message ring: watches the input, output and
// configuration ports, predicts every output beat and compares it field by field.
// Depends on lpmr_pkg.
`timescale 1ns / 1ps

module length_prefixed_message_ring_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic                          i_in_ready,
    input  wire lpmr_pkg::t_in_beat            i_in_beat,
    input  wire logic                          i_out_valid,
    input  wire logic                          i_out_ready,
    input  wire lpmr_pkg::t_out_beat           i_out_beat,
    input  wire logic                          i_psel,
    input  wire logic                          i_penable,
    input  wire logic                          i_pwrite,
    input  wire logic                          i_pready,
    input  wire logic [lpmr_pkg::PADDR_W-1:0]  i_paddr,
    input  wire logic [lpmr_pkg::PDATA_W-1:0]  i_pwdata,
    output int                                 o_fail_count,
    output int                                 o_pending
);

    import lpmr_pkg::*;

    localparam int unsigned DEPTH   = RING_DEPTH_DEF;
    localparam int unsigned MAX_LEN = MAX_MESSAGE_DEF;

    // Shadow copy of the ring and its bookkeeping.
    logic [7:0]  ring_mem [DEPTH];
    int unsigned size_reg;
    int unsigned wr_ptr;
    int unsigned rd_ptr;
    int unsigned used_cnt;
    int unsigned peak_cnt;
    bit          msg_open;
    int unsigned msg_left;
    int unsigned fill_ptr;
    int unsigned msg_len;

    // Output beats that the block still owes, oldest first.
    t_out_beat   beats_due [$];
    int          fail_cnt = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Ring size as the block uses it, clamped to the supported range.
    function automatic int unsigned ring_span();
        if (size_reg < MIN_RING) return MIN_RING;
        if (size_reg > DEPTH) return DEPTH;
        return size_reg;
    endfunction

    function automatic int unsigned ring_next(int unsigned p, int unsigned n);
        return (p + n) % ring_span();
    endfunction

    // One byte always stays free, so the capacity is the span minus one.
    function automatic int unsigned space_left();
        int unsigned cap;
        cap = ring_span() - 1;
        return (used_cnt >= cap) ? 0 : cap - used_cnt;
    endfunction

    // Little-endian length header starting at ring position p.
    function automatic int unsigned header_at(int unsigned p);
        int unsigned v;
        v = 0;
        for (int i = 0; i < HEADER_BYTES; i++)
            v = v | (32'(ring_mem[ring_next(p, i)]) << (8 * i));
        return v;
    endfunction

    function automatic void clear_ring();
        wr_ptr   = 0;
        rd_ptr   = 0;
        used_cnt = 0;
        msg_open = 1'b0;
        msg_left = 0;
        fill_ptr = 0;
        msg_len  = 0;
    endfunction

    // Queues one output beat; the status fields reflect the current state.
    function automatic void queue_beat(logic [2:0] st, logic [7:0] data, logic is_last,
                                       int unsigned cnt);
        t_out_beat   b;
        int unsigned room;
        int unsigned head;
        room = space_left();
        head = 0;
        if (used_cnt >= HEADER_BYTES) begin
            head = header_at(rd_ptr);
            if (head > MAX_LEN) head = 0;
        end
        b.status      = st;
        b.out_byte    = data;
        b.last        = is_last;
        b.count       = cnt[6:0];
        b.used_bytes  = used_cnt[9:0];
        b.free_bytes  = room[9:0];
        b.peak_bytes  = peak_cnt[9:0];
        b.next_length = head[6:0];
        b.is_empty    = (used_cnt == 0);
        b.is_full     = (room < HEADER_BYTES + 1);
        beats_due.push_back(b);
    endfunction

    // Advances the shadow ring by one accepted input beat.
    function automatic void ring_apply(t_in_beat it);
        logic [7:0]  got [MAX_LEN];
        int unsigned lim;
        int unsigned head;
        int unsigned n;
        int unsigned p;
        lim = it.length;
        case (it.action)
            ACT_SEND_BEGIN: begin
                if (msg_open)
                    queue_beat(ST_SEQ_ERR, 8'h00, 1'b1, 0);
                else if (lim == 0 || lim > MAX_LEN)
                    queue_beat(ST_BAD_LEN, 8'h00, 1'b1, 0);
                else if (space_left() < HEADER_BYTES + lim)
                    queue_beat(ST_NO_SPACE, 8'h00, 1'b1, 0);
                else begin
                    // The header goes in right away; data follows at fill_ptr.
                    p = wr_ptr;
                    for (int i = 0; i < HEADER_BYTES; i++) begin
                        ring_mem[p] = 8'(lim >> (8 * i));
                        p = ring_next(p, 1);
                    end
                    fill_ptr = p;
                    msg_len  = lim;
                    msg_left = lim;
                    msg_open = 1'b1;
                    queue_beat(ST_OK, 8'h00, 1'b1, 0);
                end
            end
            ACT_SEND_BYTE: begin
                if (!msg_open)
                    queue_beat(ST_SEQ_ERR, 8'h00, 1'b1, 0);
                else begin
                    ring_mem[fill_ptr] = it.in_byte;
                    fill_ptr = ring_next(fill_ptr, 1);
                    if (msg_left > 0) msg_left--;
                    // The last data byte commits the whole message.
                    if (msg_left == 0) begin
                        wr_ptr   = fill_ptr;
                        used_cnt = used_cnt + HEADER_BYTES + msg_len;
                        if (used_cnt > peak_cnt) peak_cnt = used_cnt;
                        msg_open = 1'b0;
                    end
                    queue_beat(ST_OK, 8'h00, 1'b1, msg_len - msg_left);
                end
            end
            ACT_RECEIVE: begin
                if (lim == 0)
                    queue_beat(ST_BAD_LEN, 8'h00, 1'b1, 0);
                else if (used_cnt < HEADER_BYTES)
                    queue_beat(ST_EMPTY, 8'h00, 1'b1, 0);
                else begin
                    head = header_at(rd_ptr);
                    if (head > MAX_LEN || used_cnt < HEADER_BYTES + head) begin
                        clear_ring();
                        queue_beat(ST_CORRUPT, 8'h00, 1'b1, 0);
                    end else begin
                        // Copy up to the limit, then drop the whole message.
                        n = (head < lim) ? head : lim;
                        p = ring_next(rd_ptr, HEADER_BYTES);
                        for (int i = 0; i < n; i++) begin
                            got[i] = ring_mem[p];
                            p = ring_next(p, 1);
                        end
                        rd_ptr   = ring_next(rd_ptr, HEADER_BYTES + head);
                        used_cnt = used_cnt - (HEADER_BYTES + head);
                        if (n == 0)
                            queue_beat(ST_OK, 8'h00, 1'b1, 0);
                        else
                            for (int i = 0; i < n; i++)
                                queue_beat(ST_OK, got[i], (i + 1 == n), i + 1);
                    end
                end
            end
            ACT_FLUSH: begin
                clear_ring();
                queue_beat(ST_OK, 8'h00, 1'b1, 0);
            end
            ACT_STATUS: begin
                queue_beat(ST_OK, 8'h00, 1'b1, 0);
            end
            default: begin
                queue_beat(ST_SEQ_ERR, 8'h00, 1'b1, 0);
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [9:0] want, logic [9:0] seen);
        if (seen !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, seen);
            fail_cnt++;
        end
    endfunction

    // Order within one edge: register writes, then the output beat against what
    // is already owed, then the input beat.
    always @(posedge i_clk) begin : watch
        t_out_beat want;
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) ring_mem[k] = 8'h00;
            size_reg = RING_SIZE_RESET;
            peak_cnt = 0;
            clear_ring();
            beats_due.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == ADDR_RING_SIZE) begin
                size_reg = i_pwdata[RING_SIZE_W-1:0];
                clear_ring();
            end
            if (i_out_valid && i_out_ready) begin
                if (beats_due.size() == 0) begin
                    $display("%0t: output beat with none expected, got status %0d byte %0d",
                             $time, i_out_beat.status, i_out_beat.out_byte);
                    fail_cnt++;
                end else begin
                    want = beats_due.pop_front();
                    check_field("status", want.status, i_out_beat.status);
                    check_field("out_byte", want.out_byte, i_out_beat.out_byte);
                    check_field("last", want.last, i_out_beat.last);
                    check_field("count", want.count, i_out_beat.count);
                    check_field("used_bytes", want.used_bytes, i_out_beat.used_bytes);
                    check_field("free_bytes", want.free_bytes, i_out_beat.free_bytes);
                    check_field("peak_bytes", want.peak_bytes, i_out_beat.peak_bytes);
                    check_field("next_length", want.next_length, i_out_beat.next_length);
                    check_field("is_empty", want.is_empty, i_out_beat.is_empty);
                    check_field("is_full", want.is_full, i_out_beat.is_full);
                end
            end
            if (i_in_valid && i_in_ready) ring_apply(i_in_beat);
        end
        o_pending    <= beats_due.size();
        o_fail_count <= fail_cnt;
    end

endmodule

// ----- dv/length_prefixed_message_ring_tb.sv -----
// Testbench top for the length-prefixed message ring: clock, reset, stimulus,
// receiver stalls and the verdict. Depends on lpmr_pkg, the block and its checker.
`timescale 1ns / 1ps

module length_prefixed_message_ring_tb;

    import lpmr_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 12;
    localparam int DRAIN_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 30;
    localparam int PHASES       = 6;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               o_in_ready;
    t_in_beat           in_beat;
    logic               o_out_valid;
    logic               out_ready;
    t_out_beat          o_out_beat;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int                 fail_count;
    int                 pending;
    int                 items_sent = 0;
    bit                 hold_request = 1'b0;
    bit                 burst_mode = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    length_prefixed_message_ring u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_beat   (in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_beat  (o_out_beat),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    length_prefixed_message_ring_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_beat    (in_beat),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .i_out_beat   (o_out_beat),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Mostly short idle gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic t_in_beat mk_beat(logic [2:0] act, logic [7:0] len, logic [7:0] data);
        t_in_beat b;
        b.action  = act;
        b.length  = len;
        b.in_byte = data;
        return b;
    endfunction

    // Offers one beat and returns at the edge that accepts it. Valid stays high
    // when the next beat follows without a gap.
    task automatic push_item(input t_in_beat b);
        int gap;
        gap = burst_mode ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        do @(posedge clk); while (!o_in_ready);
        items_sent++;
    endtask

    // Waits until every owed output beat has arrived or DRAIN_LIMIT runs out, then settles.
    task automatic drain();
        int waited;
        in_valid <= 1'b0;
        @(posedge clk);
        for (waited = 0; pending != 0 && waited < DRAIN_LIMIT; waited++)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_ring_size(input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_RING_SIZE;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic int unsigned pick_len(int unsigned cap);
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 6);
        if (r < 95) return $urandom_range(1, cap < 24 ? cap : 24);
        return cap;
    endfunction

    // A send begin and its data beats; now and then another action cuts in.
    task automatic send_message(input int unsigned len);
        push_item(mk_beat(ACT_SEND_BEGIN, 8'(len), 8'($urandom)));
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 39) == 0)
                push_item(mk_beat(3'($urandom_range(ACT_SEND_BEGIN, ACT_STATUS)),
                                  8'($urandom), 8'($urandom)));
            push_item(mk_beat(ACT_SEND_BYTE, 8'($urandom), 8'($urandom)));
        end
    endtask

    task automatic random_step(input int unsigned cap);
        int r;
        int lim;
        r = $urandom_range(0, 99);
        lim = $urandom_range(0, 99);
        if (lim < 50) lim = 255;
        else if (lim < 90) lim = $urandom_range(1, 64);
        else if (lim < 95) lim = 0;
        else lim = $urandom_range(65, 254);
        if (r < 45)
            send_message(pick_len(cap));
        else if (r < 78)
            push_item(mk_beat(ACT_RECEIVE, 8'(lim), 8'($urandom)));
        else if (r < 86)
            push_item(mk_beat(ACT_STATUS, 8'($urandom), 8'($urandom)));
        else if (r < 89)
            push_item(mk_beat(ACT_FLUSH, 8'($urandom), 8'($urandom)));
        else
            push_item(mk_beat(3'($urandom), 8'($urandom), 8'($urandom)));
    endtask

    // Register settings per phase: clamped extremes, tiny rings and the default.
    function automatic int unsigned phase_size(int ph);
        case (ph)
            0:       return 2047;
            1:       return 8;
            2:       return 0;
            3:       return 13;
            4:       return 100;
            default: return 1024;
        endcase
    endfunction

    // Receiver: random ready stalls, and one long hold when asked for.
    initial begin : receiver
        int stall;
        out_ready <= 1'b0;
        @(posedge clk);
        forever begin
            if (hold_request) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end else begin
                stall = pick_gap();
                if (stall > 0) begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    initial begin : stimulus
        int start;
        int unsigned cap;
        in_valid <= 1'b0;
        in_beat  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        rst_n    <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Refusals and odd actions on an empty ring.
        push_item(mk_beat(ACT_STATUS, 8'd0, 8'd0));
        push_item(mk_beat(ACT_RECEIVE, 8'd0, 8'd0));
        push_item(mk_beat(ACT_RECEIVE, 8'd255, 8'd0));
        push_item(mk_beat(ACT_SEND_BYTE, 8'd0, 8'hFF));
        push_item(mk_beat(ACT_SEND_BEGIN, 8'd0, 8'd0));
        push_item(mk_beat(ACT_SEND_BEGIN, 8'd65, 8'd0));
        push_item(mk_beat(ACT_SEND_BEGIN, 8'd255, 8'd0));
        push_item(mk_beat(3'd5, 8'd255, 8'hFF));
        push_item(mk_beat(3'd6, 8'd0, 8'd0));
        push_item(mk_beat(3'd7, 8'd255, 8'hFF));
        // Longest message opened, then aborted by a flush.
        push_item(mk_beat(ACT_SEND_BEGIN, 8'd64, 8'd0));
        push_item(mk_beat(ACT_FLUSH, 8'd0, 8'd0));
        // Begin while a send is open, then two committed messages.
        push_item(mk_beat(ACT_SEND_BEGIN, 8'd3, 8'd0));
        push_item(mk_beat(ACT_SEND_BEGIN, 8'd2, 8'd0));
        push_item(mk_beat(ACT_SEND_BYTE, 8'd0, 8'h00));
        push_item(mk_beat(ACT_SEND_BYTE, 8'd0, 8'hFF));
        push_item(mk_beat(ACT_SEND_BYTE, 8'd0, 8'h5A));
        push_item(mk_beat(ACT_SEND_BEGIN, 8'd2, 8'd0));
        push_item(mk_beat(ACT_SEND_BYTE, 8'd0, 8'h81));
        push_item(mk_beat(ACT_SEND_BYTE, 8'd0, 8'h7E));
        // Full read, then a read cut short by its limit.
        push_item(mk_beat(ACT_RECEIVE, 8'd255, 8'd0));
        push_item(mk_beat(ACT_RECEIVE, 8'd1, 8'd0));
        // Flush with committed data, then read the empty ring.
        push_item(mk_beat(ACT_SEND_BEGIN, 8'd1, 8'd0));
        push_item(mk_beat(ACT_SEND_BYTE, 8'd0, 8'hC3));
        push_item(mk_beat(ACT_FLUSH, 8'd0, 8'd0));
        push_item(mk_beat(ACT_RECEIVE, 8'd255, 8'd0));
        drain();

        // Random phases, each under a new ring size.
        for (int ph = 0; ph < PHASES; ph++) begin
            write_ring_size(phase_size(ph));
            cap = (phase_size(ph) >= 8 && phase_size(ph) <= 16) || phase_size(ph) < 8 ?
                  8 : 64;
            if (ph == 0) begin
                // Receiver holds off while a long message and its read pile up.
                hold_request = 1'b1;
                burst_mode   = 1'b1;
                send_message(40);
                push_item(mk_beat(ACT_RECEIVE, 8'd255, 8'd0));
                repeat (6) push_item(mk_beat(ACT_STATUS, 8'd0, 8'd0));
                burst_mode   = 1'b0;
            end
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS)
                random_step(cap);
            drain();
        end

        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin : watchdog
        #30_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/lpmr_pkg.sv
rtl/lpmr_mem.sv
rtl/lpmr_apb.sv
rtl/lpmr_ctrl.sv
rtl/length_prefixed_message_ring.sv
rtl/lpmr_checker.sv
dv/length_prefixed_message_ring_checker.sv
dv/length_prefixed_message_ring_tb.sv
